// ===== hdl/mfo_pkg.sv =====
// Shared types, constants and the arctangent table for the mecanum frame odometry block.
package mfo_pkg;

    localparam int FRAME_BYTES   = 11;
    localparam int CORDIC_STAGES = 16;
    localparam int STEP_W        = 5;
    localparam int CNT_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [7:0] SYNC_BYTE  = 8'hBB;
    localparam logic [7:0] CLOSE_BYTE = 8'hAA;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEC_TICK   = 2'd2;

    localparam logic [23:0] SPEED_GAIN_RST = 24'd74016;
    localparam logic [23:0] TURN_GAIN_RST  = 24'd160904;
    localparam logic [31:0] SEC_TICK_RST   = 32'd4295;

    localparam logic signed [19:0] CORDIC_X0   = 20'sd39797;
    localparam logic [32:0]        RAD_TO_BAM = 33'd683565276;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] arrival_stamp;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading_angle;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] yaw_rate;
    } out_beat_t;

    // Arctangent of 2^-i as a 32 bit binary angle.
    function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/mecanum_frame_odometry.sv =====
// Mecanum wheel odometry: frame assembly, shared CORDIC and multiplier sequencer, pose state.
// Bytes are taken one a cycle while idle. A frame that closes and passes its checks makes the
// block busy while the shared CORDIC adder runs its rotation steps and then the single shared
// 33 by 33 multiplier runs its steps; the result beat is loaded into the output register at
// the end of the last step. If the previous result beat is still waiting there, the last
// step holds, and the input stays stalled, until it has left. Reset clears pose, counters,
// the last frame stamp and restores the gain and tick registers; the frame store is not
// cleared.
module mecanum_frame_odometry
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mfo_pkg::in_beat_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mfo_pkg::out_beat_t                  out_data,
    input  logic                                cfg_write,
    input  logic [mfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mfo_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CORDIC = 2'd1;
    localparam logic [1:0] ST_MULT   = 2'd2;

    localparam logic [mfo_pkg::STEP_W-1:0] LAST_STAGE =
        mfo_pkg::STEP_W'(mfo_pkg::CORDIC_STAGES - 1);
    localparam logic [mfo_pkg::STEP_W-1:0] LAST_MULT = 5'd13;

    // Configuration registers.
    logic [23:0] speed_gain_reg;
    logic [23:0] turn_gain_reg;
    logic [31:0] sec_tick_reg;

    // Frame assembly.
    logic [7:0]                    store_reg [mfo_pkg::FRAME_BYTES];
    logic [mfo_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [7:0]                    prev_reg, prev_next;

    // Sequencer and working registers.
    logic [1:0]                    state_reg, state_next;
    logic [mfo_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [31:0]                   stamp_reg;
    logic                          flip_reg;
    logic signed [19:0]            cx_reg, cy_reg;
    logic signed [33:0]            cz_reg;
    logic signed [65:0]            prod_reg;
    logic signed [23:0]            vx_reg, vy_reg, wr_reg;
    logic [31:0]                   dt_reg;
    logic signed [43:0]            acc_reg;
    logic signed [27:0]            rx_reg, ry_reg;
    logic [63:0]                   p_reg;
    logic [63:0]                   lo_reg;

    // Pose state.
    logic signed [31:0]            pose_x_reg, pose_y_reg;
    logic [15:0]                   heading_reg;
    logic [31:0]                   last_stamp_reg;

    logic                          out_valid_reg;
    mfo_pkg::out_beat_t            out_data_reg;

    logic                          in_acc;
    logic                          closes;
    logic                          frame_ok;
    logic                          out_free;

    logic signed [9:0]             w1, w2, w3, w4;
    logic signed [11:0]            sx, sy, sw;
    logic signed [32:0]            mul_a, mul_b;
    logic signed [65:0]            mul_p;
    logic signed [19:0]            c_val, s_val;
    logic [31:0]                   z_fold;
    logic signed [33:0]            atan_s;
    logic signed [65:0]            rnd16;
    logic signed [65:0]            pose_sum;
    logic [63:0]                   head_sum;
    logic [47:0]                   dt_wide;

    function automatic logic signed [9:0] wheel_speed(input logic [7:0] mag,
                                                      input logic [7:0] dir);
        logic signed [9:0] m;
        m = $signed({2'b00, mag});
        if (dir == 8'd0)
        begin
            return 10'sd0;
        end
        else if (dir == 8'd1)
        begin
            return m;
        end
        return -m;
    endfunction

    function automatic logic signed [23:0] sat24_rnd8(input logic signed [65:0] p);
        logic signed [65:0] r;
        r = (p + 66'sd128) >>> 8;
        if (r > 66'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        else if (r < -66'sd8388608)
        begin
            return 24'sh800000;
        end
        return r[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // A frame closes on a second closing byte; it is good only at full length with the sync byte.
    assign closes   = (in_data.rx_byte == mfo_pkg::CLOSE_BYTE) &&
                      (prev_reg == mfo_pkg::CLOSE_BYTE) && (count_reg != '0);
    assign frame_ok = closes &&
                      (count_reg == mfo_pkg::CNT_W'(mfo_pkg::FRAME_BYTES - 1)) &&
                      (store_reg[0] == mfo_pkg::SYNC_BYTE);

    // Wheel words sit in the frame in the order 4, 2, 1, 3.
    assign w4 = wheel_speed(store_reg[1], store_reg[2]);
    assign w2 = wheel_speed(store_reg[3], store_reg[4]);
    assign w1 = wheel_speed(store_reg[5], store_reg[6]);
    assign w3 = wheel_speed(store_reg[7], store_reg[8]);
    assign sx = 12'(w1) + 12'(w2) + 12'(w3) + 12'(w4);
    assign sy = 12'(w1) - 12'(w2) - 12'(w3) + 12'(w4);
    assign sw = 12'(w1) - 12'(w2) + 12'(w3) - 12'(w4);

    // Heading folded into a quarter turn either side of zero before rotation.
    assign z_fold = {heading_reg, 16'h0000};

    assign atan_s = $signed({2'b00, mfo_pkg::atan_bam(step_reg)});
    assign c_val  = flip_reg ? -cx_reg : cx_reg;
    assign s_val  = flip_reg ? -cy_reg : cy_reg;

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            5'd0:
            begin
                mul_a = 33'(sx);
                mul_b = $signed({9'd0, speed_gain_reg});
            end
            5'd1:
            begin
                mul_a = 33'(sy);
                mul_b = $signed({9'd0, speed_gain_reg});
            end
            5'd2:
            begin
                mul_a = 33'(sw);
                mul_b = $signed({9'd0, turn_gain_reg});
            end
            5'd3:
            begin
                mul_a = $signed({1'b0, stamp_reg - last_stamp_reg});
                mul_b = $signed({1'b0, sec_tick_reg});
            end
            5'd4:
            begin
                mul_a = 33'(vx_reg);
                mul_b = 33'(c_val);
            end
            5'd5:
            begin
                mul_a = 33'(vy_reg);
                mul_b = 33'(s_val);
            end
            5'd6:
            begin
                mul_a = 33'(vx_reg);
                mul_b = 33'(s_val);
            end
            5'd7:
            begin
                mul_a = 33'(vy_reg);
                mul_b = 33'(c_val);
            end
            5'd8:
            begin
                mul_a = 33'(rx_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            5'd9:
            begin
                mul_a = 33'(ry_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            5'd10:
            begin
                mul_a = 33'(wr_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            5'd11:
            begin
                mul_a = $signed({1'b0, prod_reg[31:0]});
                mul_b = $signed(mfo_pkg::RAD_TO_BAM);
            end
            5'd12:
            begin
                mul_a = $signed({1'b0, p_reg[63:32]});
                mul_b = $signed(mfo_pkg::RAD_TO_BAM);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign rnd16    = (prod_reg + 66'sd32768) >>> 16;
    assign dt_wide  = 48'((prod_reg[63:0] + 64'h8000) >> 16);
    assign head_sum = lo_reg + {prod_reg[31:0], 32'h0} + 64'h0000_8000_0000_0000;

    always_comb
    begin
        pose_sum = '0;
        if (step_reg == 5'd9)
        begin
            pose_sum = 66'(pose_x_reg) + rnd16;
        end
        else
        begin
            pose_sum = 66'(pose_y_reg) + rnd16;
        end
    end

    // Byte counter and closing detection.
    always_comb
    begin
        count_next = count_reg;
        prev_next  = prev_reg;
        if (in_acc)
        begin
            if (closes)
            begin
                count_next = '0;
                prev_next  = '0;
            end
            else
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
                prev_next = in_data.rx_byte;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && frame_ok)
                begin
                    state_next = ST_CORDIC;
                    step_next  = '0;
                end
            end
            ST_CORDIC:
            begin
                if (step_reg == LAST_STAGE)
                begin
                    state_next = ST_MULT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MULT:
            begin
                if (step_reg == LAST_MULT)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg <= mfo_pkg::SPEED_GAIN_RST;
            turn_gain_reg  <= mfo_pkg::TURN_GAIN_RST;
            sec_tick_reg   <= mfo_pkg::SEC_TICK_RST;
            count_reg      <= '0;
            prev_reg       <= '0;
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            heading_reg    <= '0;
            last_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mfo_pkg::REG_SPEED_GAIN: speed_gain_reg <= cfg_data[23:0];
                    mfo_pkg::REG_TURN_GAIN:  turn_gain_reg  <= cfg_data[23:0];
                    mfo_pkg::REG_SEC_TICK:   sec_tick_reg   <= cfg_data;
                    default:                 ;
                endcase
            end
            count_reg <= count_next;
            prev_reg  <= prev_next;
            state_reg <= state_next;
            step_reg  <= step_next;
            // A new beat is loaded on the last step once the output register is free.
            if ((state_reg == ST_MULT) && (step_reg == LAST_MULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_MULT)
            begin
                case (step_reg)
                    5'd9:  pose_x_reg <= sat32(pose_sum);
                    5'd10: pose_y_reg <= sat32(pose_sum);
                    5'd13:
                    begin
                        if (out_free)
                        begin
                            heading_reg    <= heading_reg + head_sum[63:48];
                            last_stamp_reg <= stamp_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (in_acc && (count_reg < mfo_pkg::CNT_W'(mfo_pkg::FRAME_BYTES)))
        begin
            store_reg[count_reg] <= in_data.rx_byte;
        end
        if (in_acc && frame_ok)
        begin
            stamp_reg <= in_data.arrival_stamp;
            flip_reg  <= z_fold[31] ^ z_fold[30];
            cx_reg    <= mfo_pkg::CORDIC_X0;
            cy_reg    <= '0;
            cz_reg    <= 34'($signed(z_fold ^ {z_fold[31] ^ z_fold[30], 31'd0}));
        end
        if (state_reg == ST_CORDIC)
        begin
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - (cy_reg >>> step_reg);
                cy_reg <= cy_reg + (cx_reg >>> step_reg);
                cz_reg <= cz_reg - atan_s;
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> step_reg);
                cy_reg <= cy_reg - (cx_reg >>> step_reg);
                cz_reg <= cz_reg + atan_s;
            end
        end
        if (state_reg == ST_MULT)
        begin
            // The heading product must survive while the last step waits for the output.
            if (step_reg != LAST_MULT)
            begin
                prod_reg <= mul_p;
            end
            case (step_reg)
                5'd1:  vx_reg <= sat24_rnd8(prod_reg);
                5'd2:  vy_reg <= sat24_rnd8(prod_reg);
                5'd3:  wr_reg <= sat24_rnd8(prod_reg);
                5'd4:  dt_reg <= (dt_wide[47:32] != '0) ? 32'hFFFFFFFF : dt_wide[31:0];
                5'd5:  acc_reg <= prod_reg[43:0];
                5'd6:  rx_reg <= 28'((66'(acc_reg) - prod_reg + 66'sd32768) >>> 16);
                5'd7:  acc_reg <= prod_reg[43:0];
                5'd8:  ry_reg <= 28'((66'(acc_reg) + prod_reg + 66'sd32768) >>> 16);
                5'd11: p_reg <= prod_reg[63:0];
                5'd12: lo_reg <= prod_reg[63:0];
                5'd13:
                begin
                    if (out_free)
                    begin
                        out_data_reg.pos_x         <= pose_x_reg;
                        out_data_reg.pos_y         <= pose_y_reg;
                        out_data_reg.heading_angle <= heading_reg + head_sum[63:48];
                        out_data_reg.vel_x         <= vx_reg;
                        out_data_reg.vel_y         <= vy_reg;
                        out_data_reg.yaw_rate      <= wr_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
